@@ rtl/swpe_pkg.sv @@
// Shared types and constants of the sliding window peak extractor.
// No dependencies; used by the top level and the centroid divider.
`timescale 1ns / 1ps
`default_nettype none

package swpe_pkg;

  // Window length register.
  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd6;

  // Result field widths.
  localparam int unsigned OUT_SUM_W = 22;
  localparam int unsigned PEAK_W    = 8;
  localparam logic [PEAK_W-1:0] PEAK_MAX = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE
  } state_e;

  // Status of the centroid divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

@@ rtl/swpe_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; a read of the address being written returns the old data.
`timescale 1ns / 1ps
`default_nettype none

module swpe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/swpe_div.sv @@
// Iterative restoring divider for the peak time centroid, one quotient bit
// per cycle, saturating at the largest peak time. Depends on swpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swpe_div #(
  parameter int unsigned NUM_W = 30,
  parameter int unsigned DEN_W = 22
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [NUM_W-1:0]              num_i,
  input  wire logic [DEN_W-1:0]              den_i,
  output swpe_pkg::div_stat_t                stat_o,
  output logic      [swpe_pkg::PEAK_W-1:0]   quot_o
);

  localparam int unsigned QW    = swpe_pkg::PEAK_W;
  localparam int unsigned HI_W  = NUM_W - QW;
  localparam int unsigned CMP_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [QW-1:0]    lo_q;
  logic [QW-1:0]    quot_q;
  logic [DEN_W-1:0] den_q;

  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] den_ext;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;
  logic             zero_den;
  logic             saturate;

  always_comb begin
    hi_ext   = CMP_W'(num_i[NUM_W-1:QW]);
    den_ext  = CMP_W'(den_i);
    zero_den = (den_i == '0);
    // The quotient exceeds the peak time range exactly when num >= den * 2^QW.
    saturate = (hi_ext >= den_ext);
    trial    = {rem_q, lo_q[QW-1]};
    fits     = (trial >= {1'b0, den_q});
    diff     = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      if (zero_den || saturate) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CNT_W'(QW);
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (zero_den) begin
        quot_q <= '0;
      end else if (saturate) begin
        quot_q <= swpe_pkg::PEAK_MAX;
      end else begin
        quot_q <= '0;
        rem_q  <= DEN_W'(hi_ext);
        lo_q   <= num_i[QW-1:0];
        den_q  <= den_i;
      end
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_q   <= {lo_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

@@ rtl/sliding_window_peak_extractor.sv @@
// Sliding window peak extractor: running window sums over a sample ring RAM
// and a per-pixel centroid. Depends on swpe_pkg, swpe_ram and swpe_div.
//
//   Channel   Direction   Handshake                 Payload
//   in        sink        in_valid_i / in_stall_o   sample, last_in_pixel, last_in_event
//   out       source      out_valid_o / out_stall_i window_sum_max, peak_time, flags
//   cfg       sink        cfg_we_i                  cfg_wdata_i (window_size)
//
// Each sample is accepted in the idle state, which reads the oldest window
// sample from the ring RAM; its registered read data is used in the update state.
// The last sample of a pixel then starts the centroid divider (one quotient
// bit per cycle, none when the sum is zero or the peak time saturates), and
// the output register is loaded once the divider is done and the output is free.
// A result waiting on a stalled output does not block new samples; only a
// second finished pixel waits for it. Reset clears all pixel state at once.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_peak_extractor #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLES_MAX = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [swpe_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [15:0]                         sample_i,
  input  wire logic                                last_in_pixel_i,
  input  wire logic                                last_in_event_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [swpe_pkg::OUT_SUM_W-1:0]      window_sum_max_o,
  output logic      [swpe_pkg::PEAK_W-1:0]         peak_time_o,
  output logic                                     short_pixel_o,
  output logic                                     too_long_o,
  output logic                                     last_pixel_o
);

  localparam int unsigned WIN_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned IDX_W  = $clog2(SAMPLES_MAX + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int unsigned WSUM_W = SUM_W + $clog2(SAMPLES_MAX);
  localparam int unsigned CW     = ((IDX_W > WIN_W) ? IDX_W : WIN_W) + 1;
  localparam int unsigned PROD_W = SAMPLE_BITS + IDX_W;
  localparam int unsigned CFG_W  = swpe_pkg::CFG_W;

  // Control and pixel state.
  swpe_pkg::state_e  state_q, state_d;
  logic [CFG_W-1:0]  cfg_win_q;
  logic [WIN_W-1:0]  pix_win_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [SUM_W-1:0]  ws_q;
  logic [WSUM_W-1:0] wws_q;
  logic [SUM_W-1:0]  best_q;
  logic [WSUM_W-1:0] bwws_q;
  logic              ovf_q;
  logic              out_valid_q;

  // Request held between accept and update.
  logic [SAMPLE_BITS-1:0] s_q;
  logic [WSUM_W-1:0]      prod_q;
  logic [IDX_W-1:0]       lag_q;
  logic                   has_old_q;
  logic                   first_win_q;
  logic                   past_win_q;
  logic                   in_range_q;
  logic                   last_q;
  logic                   ev_q;

  // Pixel result waiting on the divider, and the output register.
  logic [swpe_pkg::OUT_SUM_W-1:0] res_sum_q;
  logic                           res_short_q;
  logic                           res_long_q;
  logic                           res_ev_q;
  logic [swpe_pkg::OUT_SUM_W-1:0] out_sum_q;
  logic [swpe_pkg::PEAK_W-1:0]    out_peak_q;
  logic                           out_short_q;
  logic                           out_long_q;
  logic                           out_ev_q;

  logic accept;
  logic div_start;
  logic out_load;
  logic out_free;

  // Accept-side signals.
  logic [SAMPLE_BITS-1:0] s_in;
  logic [WIN_W-1:0]       eff_win;
  logic [WIN_W-1:0]       win_cur;
  logic                   in_range_a;
  logic                   has_old_a;
  logic [CW-1:0]          idx_p1;
  logic [WIN_W:0]         rd_calc;
  logic [PTR_W-1:0]       rd_addr;
  logic [PROD_W-1:0]      new_prod;

  // Update-side signals.
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] old;
  logic [PROD_W-1:0]      old_prod;
  logic [SUM_W-1:0]       ws_new;
  logic [WSUM_W-1:0]      wws_new;
  logic                   upd_best;
  logic [IDX_W-1:0]       idx_new;
  logic [SUM_W-1:0]       ws_cur;
  logic [WSUM_W-1:0]      wws_cur;
  logic [SUM_W-1:0]       best_cur;
  logic [WSUM_W-1:0]      bwws_cur;
  logic                   is_short;
  logic [SUM_W-1:0]       rsum;
  logic [WSUM_W-1:0]      rw;

  swpe_pkg::div_stat_t         div_stat;
  logic [swpe_pkg::PEAK_W-1:0] div_quot;

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swpe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      swpe_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = swpe_pkg::ST_UPDATE;
        end
      end
      swpe_pkg::ST_UPDATE: begin
        if (last_q) begin
          div_start = 1'b1;
          state_d   = swpe_pkg::ST_DIVIDE;
        end else begin
          state_d = swpe_pkg::ST_IDLE;
        end
      end
      swpe_pkg::ST_DIVIDE: begin
        if (div_stat.done && out_free) begin
          out_load = 1'b1;
          state_d  = swpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swpe_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Accept: window bookkeeping and ring RAM access
  // ---------------------------------------------------------------------

  always_comb begin
    s_in = sample_i[SAMPLE_BITS-1:0];
    if (cfg_win_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (32'(cfg_win_q) > WINDOW_MAX) begin
      eff_win = WIN_W'(WINDOW_MAX);
    end else begin
      eff_win = WIN_W'(cfg_win_q);
    end
    // The window length is taken at the first sample of each pixel.
    win_cur    = (idx_q == '0) ? eff_win : pix_win_q;
    in_range_a = (32'(idx_q) < SAMPLES_MAX);
    has_old_a  = (CW'(idx_q) >= CW'(win_cur));
    idx_p1     = CW'(idx_q) + CW'(1);
    // Ring slot of the sample leaving the window.
    if ((WIN_W + 1)'(wr_ptr_q) >= (WIN_W + 1)'(win_cur)) begin
      rd_calc = (WIN_W + 1)'(wr_ptr_q) - (WIN_W + 1)'(win_cur);
    end else begin
      rd_calc = (WIN_W + 1)'(wr_ptr_q) + (WIN_W + 1)'(WINDOW_MAX)
              - (WIN_W + 1)'(win_cur);
    end
    rd_addr  = rd_calc[PTR_W-1:0];
    new_prod = s_in * idx_q;
  end

  // When the window spans the whole ring, the read and the write hit the same
  // slot in the accept cycle; the RAM returns the old sample, as needed.
  swpe_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && in_range_a),
    .waddr_i (wr_ptr_q),
    .wdata_i (s_in),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q         <= s_in;
      prod_q      <= WSUM_W'(new_prod);
      lag_q       <= idx_q - IDX_W'(win_cur);
      has_old_q   <= has_old_a;
      first_win_q <= (idx_p1 == CW'(win_cur));
      past_win_q  <= (idx_p1 > CW'(win_cur));
      in_range_q  <= in_range_a;
      last_q      <= last_in_pixel_i;
      ev_q        <= last_in_event_i;
    end
  end

  // ---------------------------------------------------------------------
  // Update: slide the window and track the best one
  // ---------------------------------------------------------------------

  always_comb begin
    old      = has_old_q ? ram_rdata : '0;
    old_prod = old * lag_q;
    ws_new   = ws_q - SUM_W'(old) + SUM_W'(s_q);
    wws_new  = wws_q - WSUM_W'(old_prod) + prod_q;
    // The first full window always counts; later ones only on a strict gain.
    upd_best = in_range_q && (first_win_q || (past_win_q && (ws_new > best_q)));
    idx_new  = in_range_q ? (idx_q + IDX_W'(1)) : idx_q;
    ws_cur   = in_range_q ? ws_new : ws_q;
    wws_cur  = in_range_q ? wws_new : wws_q;
    best_cur = upd_best ? ws_new : best_q;
    bwws_cur = upd_best ? wws_new : bwws_q;
    is_short = (CW'(idx_new) < CW'(pix_win_q));
    rsum     = is_short ? ws_cur : best_cur;
    rw       = is_short ? wws_cur : bwws_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_win_q <= swpe_pkg::WINDOW_SIZE_RST;
      pix_win_q <= WIN_W'(1);
      idx_q     <= '0;
      wr_ptr_q  <= '0;
      ws_q      <= '0;
      wws_q     <= '0;
      best_q    <= '0;
      bwws_q    <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_win_q <= cfg_wdata_i;
      end
      if (accept && (idx_q == '0)) begin
        pix_win_q <= eff_win;
      end
      if (state_q == swpe_pkg::ST_UPDATE) begin
        if (last_q) begin
          idx_q    <= '0;
          wr_ptr_q <= '0;
          ws_q     <= '0;
          wws_q    <= '0;
          best_q   <= '0;
          bwws_q   <= '0;
          ovf_q    <= 1'b0;
        end else begin
          idx_q  <= idx_new;
          ws_q   <= ws_cur;
          wws_q  <= wws_cur;
          best_q <= best_cur;
          bwws_q <= bwws_cur;
          ovf_q  <= ovf_q || !in_range_q;
          if (in_range_q) begin
            if (32'(wr_ptr_q) == WINDOW_MAX - 1) begin
              wr_ptr_q <= '0;
            end else begin
              wr_ptr_q <= wr_ptr_q + PTR_W'(1);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Centroid and output register
  // ---------------------------------------------------------------------

  swpe_div #(
    .NUM_W (WSUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rw),
    .den_i   (rsum),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      res_sum_q   <= swpe_pkg::OUT_SUM_W'(rsum);
      res_short_q <= is_short;
      res_long_q  <= ovf_q || !in_range_q;
      res_ev_q    <= ev_q;
    end
    if (out_load) begin
      out_sum_q   <= res_sum_q;
      out_peak_q  <= div_quot;
      out_short_q <= res_short_q;
      out_long_q  <= res_long_q;
      out_ev_q    <= res_ev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign window_sum_max_o = out_sum_q;
  assign peak_time_o      = out_peak_q;
  assign short_pixel_o    = out_short_q;
  assign too_long_o       = out_long_q;
  assign last_pixel_o     = out_ev_q;

`ifndef SYNTHESIS
  // The sample counter stops at the maximum pixel length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) <= SAMPLES_MAX)
    else $error("sample index beyond maximum pixel length");

  // A pixel end clears the pixel state for the next pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swpe_pkg::ST_UPDATE) && last_q |=> (idx_q == '0) && (ws_q == '0))
    else $error("pixel state not cleared after last sample");

  // The divider is never restarted while it is still iterating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // An accepted request is always followed by its update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == swpe_pkg::ST_UPDATE))
    else $error("accepted request without update");

  // Within a pixel the latched window length stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (pix_win_q != '0) && (32'(pix_win_q) <= WINDOW_MAX))
    else $error("latched window length out of range");
`endif

endmodule

`default_nettype wire
